>>> src/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 instruction executor.
`default_nettype none
package c8ie_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_REG   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;
    localparam logic [2:0] ST_NOIMPL  = 3'd5;

    // memory address select
    typedef enum logic [1:0] {
        MA_CMD = 2'd0,
        MA_PC  = 2'd1,
        MA_SP  = 2'd2
    } maddr_sel_t;

    typedef struct packed {
        logic       latch_in;   // capture the transaction
        logic       mem_rd;
        maddr_sel_t mem_sel;
        logic       mem_plus1;  // address + 1
        logic       mem_wr;
        logic       wr_hi;      // write return address high byte
        logic       wr_lo;
        logic       wr_data;    // write command data
        logic       cap_b0;
        logic       cap_b1;
        logic       cap_pop_hi;
        logic       execute;    // decode and commit
        logic       pop_commit;
        logic       push_commit;
        logic       clr_step;
        logic       finish;     // strobe result
    } c8ie_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       range_err;
        logic       is_cls;
        logic       is_ret;
        logic       is_call;
        logic       stack_empty;
        logic       stack_full;
        logic       clr_last;
    } c8ie_stat_t;
endpackage
`default_nettype wire

>>> src/c8ie_ctrl.sv
// Controller sequencing memory accesses for each command.
`default_nettype none
module c8ie_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  c8ie_pkg::c8ie_stat_t   stat,
    output c8ie_pkg::c8ie_cmd_t    cmd
);
    import c8ie_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_F1    = 10'b0000000100,
        S_F2    = 10'b0000001000,
        S_DEC   = 10'b0000010000,
        S_POP   = 10'b0000100000,
        S_PUSH  = 10'b0001000000,
        S_CLR   = 10'b0010000000,
        S_DONE  = 10'b0100000000,
        S_INIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.mem_sel = MA_CMD;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.command)
                    CMD_WRITE:
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.wr_data = 1'b1;
                        state_next = S_DONE;
                    end
                    CMD_READ:
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = S_DONE;
                    end
                    CMD_REG:
                    begin
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (stat.range_err)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.mem_rd = 1'b1;
                            cmd.mem_sel = MA_PC;
                            state_next = S_F1;
                        end
                    end
                endcase
            end
            S_F1:
            begin
                cmd.cap_b0 = 1'b1;
                cmd.mem_rd = 1'b1;
                cmd.mem_sel = MA_PC;
                cmd.mem_plus1 = 1'b1;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd.cap_b1 = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.is_ret && !stat.stack_empty)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.mem_sel = MA_SP;
                    state_next = S_POP;
                end
                else if (stat.is_call && !stat.stack_full)
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.mem_sel = MA_SP;
                    cmd.wr_hi = 1'b1;
                    state_next = S_PUSH;
                end
                else if (stat.is_cls)
                begin
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.execute = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_POP:
            begin
                cmd.cap_pop_hi = 1'b1;
                cmd.mem_rd = 1'b1;
                cmd.mem_sel = MA_SP;
                cmd.mem_plus1 = 1'b1;
                state_next = S_DONE;
                cmd.pop_commit = 1'b1;
            end
            S_PUSH:
            begin
                cmd.mem_wr = 1'b1;
                cmd.mem_sel = MA_SP;
                cmd.mem_plus1 = 1'b1;
                cmd.wr_lo = 1'b1;
                cmd.push_commit = 1'b1;
                state_next = S_DONE;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.execute = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/c8ie_dp.sv
// Datapath: memory, registers, frame buffer and instruction execution.
`default_nettype none
module c8ie_dp
#(
    parameter int MEM_BYTES     = 4096,
    parameter int DISPLAY_BYTES = 256,
    parameter int STACK_BASE    = 3744,
    parameter int STACK_LIMIT   = 3776,
    parameter int PROGRAM_START = 512
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       command,
    input  wire logic [11:0]      address,
    input  wire logic [7:0]       data,
    input  wire logic [7:0]       random_byte,
    input  c8ie_pkg::c8ie_cmd_t   cmd,
    output c8ie_pkg::c8ie_stat_t  stat,
    output logic                  done,
    output logic [2:0]            status,
    output logic [15:0]           program_counter,
    output logic [11:0]           index_value,
    output logic [11:0]           stack_position,
    output logic [7:0]            read_data
);
    import c8ie_pkg::*;

    localparam int DW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  fb  [DISPLAY_BYTES];
    logic [7:0]  v_reg [16];
    logic [15:0] pc_reg;
    logic [11:0] i_reg;
    logic [11:0] sp_reg;
    logic [1:0]  cmd_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  rnd_reg;
    logic [7:0]  b0_reg, b1_reg, pop_hi_reg, mrd_reg;
    logic [2:0]  st_reg;
    logic [DW-1:0] clr_reg;
    logic        pop_pending_reg;
    logic [7:0]  rd_sel;

    logic [11:0] base, maddr;
    logic [15:0] pc2, pc4, ret;
    logic [3:0]  x, y, n;
    logic [7:0]  vx, vy;
    logic [11:0] nnn;
    logic [8:0]  sum9;
    logic        alu_flag;
    logic [7:0]  flag8, ux, uy, alu_res;

    assign x = b0_reg[3:0];
    assign y = b1_reg[7:4];
    assign n = b1_reg[3:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];
    assign nnn = {x, b1_reg};
    assign pc2 = pc_reg + 16'd2;
    assign pc4 = pc_reg + 16'd4;
    assign ret = pc2;

    always_comb
    begin
        case (cmd.mem_sel)
            MA_PC:   base = pc_reg[11:0];
            MA_SP:   base = cmd.wr_hi || cmd.wr_lo ? sp_reg : sp_reg - 12'd2;
            default: base = addr_reg;
        endcase
        maddr = base + {11'd0, cmd.mem_plus1};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[maddr] <= cmd.wr_data ? data_reg : (cmd.wr_hi ? ret[15:8] : ret[7:0]);
        end
        if (cmd.mem_rd)
        begin
            mrd_reg <= mem[maddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            fb[clr_reg] <= '0;
        end
    end

    always_comb
    begin
        stat.command = cmd_reg;
        stat.range_err = ({16'd0, pc_reg} + 32'd1) >= 32'(MEM_BYTES);
        stat.is_cls = (b0_reg == 8'h00) && (b1_reg == 8'hE0);
        stat.is_ret = (b0_reg == 8'h00) && (b1_reg == 8'hEE);
        stat.is_call = (b0_reg[7:4] == 4'h2);
        stat.stack_empty = {20'd0, sp_reg} < 32'(STACK_BASE + 2);
        stat.stack_full = ({20'd0, sp_reg} + 32'd2) > 32'(STACK_LIMIT);
        stat.clr_last = ({{(32-DW){1'b0}}, clr_reg} == 32'(DISPLAY_BYTES - 1));
    end

    // For 8xy5 to 8xy7, VF is written first, then Vx is computed from the updated registers
    always_comb
    begin
        sum9 = {1'b0, vx} + {1'b0, vy};
        case (n[2:0])
            3'd4:    alu_flag = sum9[8];
            3'd5:    alu_flag = vx > vy;
            3'd6:    alu_flag = vx[0];
            3'd7:    alu_flag = vy > vx;
            default: alu_flag = 1'b0;
        endcase
        flag8 = {7'd0, alu_flag};
        ux = (x == 4'hF) ? flag8 : vx;
        uy = (y == 4'hF) ? flag8 : vy;
        case (n[2:0])
            3'd0:    alu_res = vy;
            3'd1:    alu_res = vx | vy;
            3'd2:    alu_res = vx & vy;
            3'd3:    alu_res = vx ^ vy;
            3'd4:    alu_res = sum9[7:0];
            3'd5:    alu_res = ux - uy;
            3'd6:    alu_res = {1'b0, ux[7:1]};
            default: alu_res = uy - ux;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg <= command;
            addr_reg <= address;
            data_reg <= data;
            rnd_reg <= random_byte;
        end
        if (cmd.cap_b0)
        begin
            b0_reg <= mrd_reg;
        end
        if (cmd.cap_b1)
        begin
            b1_reg <= mrd_reg;
        end
        if (cmd.cap_pop_hi)
        begin
            pop_hi_reg <= mrd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 16'(PROGRAM_START);
            i_reg <= '0;
            sp_reg <= 12'(STACK_BASE);
            st_reg <= ST_OK;
            clr_reg <= '0;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.latch_in)
            begin
                st_reg <= ST_OK;
                clr_reg <= '0;
            end
            if (cmd.latch_in == 1'b0 && cmd_reg == CMD_EXEC && stat.range_err
                && cmd.finish == 1'b0 && cmd.mem_sel == MA_CMD && !cmd.execute
                && !cmd.cap_b0 && !cmd.cap_b1 && !cmd.clr_step && !cmd.cap_pop_hi)
            begin
                st_reg <= ST_RANGE;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + DW'(1);
            end
            if (cmd.push_commit)
            begin
                sp_reg <= sp_reg + 12'd2;
                pc_reg <= {4'd0, nnn};
            end
            if (cmd.pop_commit)
            begin
                sp_reg <= sp_reg - 12'd2;
            end
            if (cmd.execute)
            begin
                unique case (b0_reg[7:4])
                    4'h0:
                    begin
                        if (stat.is_cls)
                        begin
                            pc_reg <= pc2;
                        end
                        else if (stat.is_ret)
                        begin
                            st_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            st_reg <= ST_UNKNOWN;
                        end
                    end
                    4'h1: pc_reg <= {4'd0, nnn};
                    4'h2: st_reg <= ST_FULL;
                    4'h3: pc_reg <= (vx == b1_reg) ? pc4 : pc2;
                    4'h4: pc_reg <= (vx != b1_reg) ? pc4 : pc2;
                    4'h5: pc_reg <= (vx == vy) ? pc4 : pc2;
                    4'h6:
                    begin
                        v_reg[x] <= b1_reg;
                        pc_reg <= pc2;
                    end
                    4'h7:
                    begin
                        v_reg[x] <= vx + b1_reg;
                        pc_reg <= pc2;
                    end
                    4'h8:
                    begin
                        if (n[3])
                        begin
                            st_reg <= ST_UNKNOWN;
                        end
                        else
                        begin
                            pc_reg <= pc2;
                            v_reg[x] <= alu_res;
                            if (n[2] && x != 4'hF)
                            begin
                                v_reg[15] <= flag8;
                            end
                        end
                    end
                    4'h9: pc_reg <= (vx != vy) ? pc4 : pc2;
                    4'hA:
                    begin
                        i_reg <= nnn;
                        pc_reg <= pc2;
                    end
                    4'hB: pc_reg <= {4'd0, nnn} + {8'd0, v_reg[0]};
                    4'hC:
                    begin
                        v_reg[x] <= rnd_reg & b1_reg;
                        pc_reg <= pc2;
                    end
                    default: st_reg <= ST_NOIMPL;
                endcase
            end
            if (cmd.finish && cmd_reg == CMD_EXEC && stat.is_ret && st_reg == ST_OK
                && b0_reg == 8'h00 && !stat.range_err && pop_pending_reg)
            begin
                pc_reg <= {4'd0, pop_hi_reg[3:0], mrd_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_pending_reg <= 1'b0;
        end
        else
        begin
            pop_pending_reg <= cmd.pop_commit;
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_READ: rd_sel = mrd_reg;
            CMD_REG:  rd_sel = v_reg[addr_reg[3:0]];
            default:  rd_sel = 8'd0;
        endcase
    end

    assign done = cmd.finish;
    assign status = st_reg;
    assign program_counter = pop_pending_reg ? {4'd0, pop_hi_reg[3:0], mrd_reg} : pc_reg;
    assign index_value = i_reg;
    assign stack_position = sp_reg;
    assign read_data = rd_sel;
    logic unused_fb;
    assign unused_fb = ^fb[0];
endmodule
`default_nettype wire

>>> src/chip8_instruction_executor_top.sv
// Top level of the CHIP-8 instruction executor.
//   channel  | signals                                   | handshake
//   command  | command, address, data, random_byte       | start && !busy
//   result   | status, program_counter, index_value,     | done (one cycle)
//            | stack_position, read_data                 |
// Memory and register commands go from dispatch straight to done; instructions
// are fetched in two reads, decoded and executed, a push or pop then moving its
// second byte through the single memory port; a fetch past memory goes straight
// to done. 00E0 clears the display one byte per cycle. Reset, with busy high,
// sets registers, pointers, then clears the display. The result cannot be stalled.
`default_nettype none
module chip8_instruction_executor_top
#(
    parameter int MEM_BYTES     = 4096,
    parameter int DISPLAY_BYTES = 256,
    parameter int STACK_BASE    = 3744,
    parameter int STACK_LIMIT   = 3776,
    parameter int PROGRAM_START = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [11:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [7:0]  random_byte,
    output logic             done,
    output logic [2:0]       status,
    output logic [15:0]      program_counter,
    output logic [11:0]      index_value,
    output logic [11:0]      stack_position,
    output logic [7:0]       read_data
);
    import c8ie_pkg::*;

    c8ie_cmd_t  cmd;
    c8ie_stat_t stat;

    c8ie_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    c8ie_dp #(
        .MEM_BYTES     (MEM_BYTES),
        .DISPLAY_BYTES (DISPLAY_BYTES),
        .STACK_BASE    (STACK_BASE),
        .STACK_LIMIT   (STACK_LIMIT),
        .PROGRAM_START (PROGRAM_START)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .address         (address),
        .data            (data),
        .random_byte     (random_byte),
        .cmd             (cmd),
        .stat            (stat),
        .done            (done),
        .status          (status),
        .program_counter (program_counter),
        .index_value     (index_value),
        .stack_position  (stack_position),
        .read_data       (read_data)
    );
endmodule
`default_nettype wire
